// ===== sv/srvm_pkg.sv =====
// Shared opcodes, fault codes and controller command types for the VM executor.
package srvm_pkg;

  localparam logic [4:0] OP_POP   = 5'd0;
  localparam logic [4:0] OP_PUSH  = 5'd1;
  localparam logic [4:0] OP_ADD   = 5'd2;
  localparam logic [4:0] OP_MUL   = 5'd3;
  localparam logic [4:0] OP_SUB   = 5'd4;
  localparam logic [4:0] OP_DIV   = 5'd5;
  localparam logic [4:0] OP_ADDI  = 5'd6;
  localparam logic [4:0] OP_MULI  = 5'd7;
  localparam logic [4:0] OP_SUBI  = 5'd8;
  localparam logic [4:0] OP_DIVI  = 5'd9;
  localparam logic [4:0] OP_LOAD  = 5'd10;
  localparam logic [4:0] OP_LOADI = 5'd11;
  localparam logic [4:0] OP_MOV   = 5'd12;
  localparam logic [4:0] OP_JMP   = 5'd13;
  localparam logic [4:0] OP_JMPC  = 5'd14;
  localparam logic [4:0] OP_COM   = 5'd15;
  localparam logic [4:0] OP_NEG   = 5'd16;
  localparam logic [4:0] OP_CALL  = 5'd17;
  localparam logic [4:0] OP_RET   = 5'd18;
  localparam logic [4:0] OP_PRINT = 5'd19;
  localparam logic [4:0] OP_EQ    = 5'd20;
  localparam logic [4:0] OP_NEQ   = 5'd21;
  localparam logic [4:0] OP_CLR   = 5'd22;
  localparam logic [4:0] OP_SET   = 5'd23;
  localparam logic [4:0] OP_ST    = 5'd24;
  localparam logic [4:0] OP_INC   = 5'd25;
  localparam logic [4:0] OP_DEC   = 5'd26;
  localparam logic [4:0] OP_JMPBC = 5'd27;
  localparam logic [4:0] OP_SIS   = 5'd28;
  localparam logic [4:0] OP_HALT  = 5'd29;

  localparam logic [2:0] F_NONE  = 3'd0;
  localparam logic [2:0] F_DIVZ  = 3'd1;
  localparam logic [2:0] F_UNDER = 3'd2;
  localparam logic [2:0] F_OVER  = 3'd3;
  localparam logic [2:0] F_INDEX = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic read;      // read register operands and memories for the held item
    logic exec;      // evaluate and commit a single-step instruction
    logic div_start; // load the divider
    logic div_step;  // one quotient bit
    logic div_done;  // write the quotient back
    logic save_step; // copy one frame word (register, status or pc) into the call frame
    logic save_done; // raise the call depth, load pc, enter the callee
    logic rest_rd;   // read one frame word
    logic rest_step; // restore one register, or latch the status word
    logic rest_done; // restore status and pc
  } srvm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_div;
    logic is_call;
    logic is_ret;
    logic last;      // the current iteration is the final one
  } srvm_stat_t;

endpackage

// ===== sv/srvm_ctrl.sv =====
// Controller state machine of the VM executor.
module srvm_ctrl
  import srvm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  srvm_stat_t stat,
  output srvm_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_EXEC = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_DIVW = 4'd4;
  localparam logic [3:0] S_SAVE = 4'd5;
  localparam logic [3:0] S_RRD  = 4'd6;
  localparam logic [3:0] S_RST  = 4'd7;
  localparam logic [3:0] S_RFIN = 4'd8;

  logic [3:0] state, state_next;
  logic       ovalid, ovalid_next;

  // The result register frees as the next item is taken, so idle means ready once the result is gone or leaving.
  assign in_ready  = (state == S_IDLE) && (!ovalid || out_ready);
  assign out_valid = ovalid;

  always_comb begin
    state_next  = state;
    ovalid_next = ovalid && !out_ready;
    cmd = '0;
    case (state)
      S_IDLE: if (in_valid && in_ready) state_next = S_READ;
      S_READ: begin
        cmd.read = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.is_div) begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end else if (stat.is_call) begin
          state_next = S_SAVE;
        end else if (stat.is_ret) begin
          state_next = S_RRD;
        end else begin
          cmd.exec = 1'b1;
          ovalid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.last) state_next = S_DIVW;
      end
      S_DIVW: begin
        cmd.div_done = 1'b1;
        ovalid_next = 1'b1;
        state_next = S_IDLE;
      end
      S_SAVE: begin
        cmd.save_step = 1'b1;
        if (stat.last) begin
          cmd.save_done = 1'b1;
          ovalid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RRD: begin
        cmd.rest_rd = 1'b1;
        state_next = S_RST;
      end
      S_RST: begin
        cmd.rest_step = 1'b1;
        cmd.rest_rd = 1'b1;
        if (stat.last) state_next = S_RFIN;
      end
      S_RFIN: begin
        cmd.rest_done = 1'b1;
        ovalid_next = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      ovalid <= ovalid_next;
    end
  end

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && !stat.is_div && !stat.is_call && !stat.is_ret) |=> ovalid)
    else $error("single-step instruction gave no result");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready)
    else $error("item accepted while busy");
  a_read_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == S_READ)
    else $error("accepted item not read");

endmodule

// ===== sv/srvm_dp.sv =====
// Datapath of the VM executor: registers, memories, stacks, divider and frame copy.
module srvm_dp
  import srvm_pkg::*;
#(
  parameter int REG_COUNT   = 32,
  parameter int MEM_WORDS   = 4096,
  parameter int STACK_DEPTH = 256,
  parameter int CALL_LEVELS = 16,
  parameter int PC_BITS     = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [4:0]         op,
  input  logic signed [31:0] first_operand,
  input  logic signed [31:0] second_operand,
  input  srvm_cmd_t          cmd,
  output srvm_stat_t         stat,
  output logic [15:0]        next_pc,
  output logic               print_valid,
  output logic signed [31:0] print_value,
  output logic               halted,
  output logic [2:0]         fault
);

  localparam int RB = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int MB = $clog2(MEM_WORDS);
  localparam int SB = $clog2(STACK_DEPTH);
  localparam int CB = $clog2(CALL_LEVELS + 1);
  localparam int LB = (CALL_LEVELS > 1) ? $clog2(CALL_LEVELS) : 1;
  localparam int FW = REG_COUNT + 2;
  localparam int FB = $clog2(CALL_LEVELS * FW);

  // Held item.
  logic [4:0]  iop;
  logic [31:0] ia, ib;

  logic [31:0]        rf [REG_COUNT];
  logic               cstat;
  logic [PC_BITS-1:0] pc;
  logic [31:0]        dmem [MEM_WORDS];
  logic [31:0]        dstk [STACK_DEPTH];
  logic [SB:0]        dsp;
  logic [31:0]        frames [CALL_LEVELS * FW];
  logic [CB-1:0]      depth;

  logic [31:0] rd, rs, mem_q, stk_q, frm_q;
  logic [RB:0] cnt;
  logic        ra_ok, rb_ok, uses_a, uses_b, idx_bad;
  logic [RB-1:0] ra, rbi;

  // Status word captured when the restore walk passes it.
  logic        cst_q;
  logic [2:0]  fault_q;
  logic [2:0]  fault_c;
  logic [31:0] save_word;

  assign ra_ok  = ia < 32'(REG_COUNT);
  assign rb_ok  = ib < 32'(REG_COUNT);
  assign ra     = ra_ok ? ia[RB-1:0] : '0;
  assign rbi    = rb_ok ? ib[RB-1:0] : '0;
  assign uses_a = (iop <= OP_MOV) || iop == OP_COM || iop == OP_NEG || iop == OP_PRINT ||
                  (iop >= OP_EQ && iop <= OP_DEC);
  assign uses_b = (iop >= OP_ADD && iop <= OP_DIV) || iop == OP_MOV || iop == OP_EQ ||
                  iop == OP_NEQ || iop == OP_ST;
  assign idx_bad = (uses_a && !ra_ok) || (uses_b && !rb_ok);

  // Frame base for the call / return in progress.
  logic [LB-1:0] lvl;
  logic [FB-1:0] base;
  assign lvl  = (iop == OP_RET) ? LB'(depth - 1'b1) : LB'(depth);
  assign base = FB'(lvl) * FB'(FW);

  assign stat.is_div  = !idx_bad && ((iop == OP_DIV && rs != 0) || (iop == OP_DIVI && ib != 0));
  assign stat.is_call = iop == OP_CALL && depth < CB'(CALL_LEVELS);
  assign stat.is_ret  = iop == OP_RET && depth != 0;

  // Divider: restoring, one quotient bit per cycle on magnitudes.
  logic [31:0] dq, dr, dd;
  logic        dneg;
  logic [4:0]  dcnt;
  logic [32:0] trial;
  assign trial = {dr[31:0], dq[31]} - {1'b0, dd};

  // Frame walks cover the registers, then the status word, then the PC.
  assign stat.last = (cmd.div_step) ? (dcnt == '0) : (cnt == (RB+1)'(REG_COUNT + 1));

  assign save_word = (cnt < (RB+1)'(REG_COUNT)) ? rf[cnt[RB-1:0]] :
                     (cnt == (RB+1)'(REG_COUNT)) ? {31'd0, cstat} : 32'(pc);

  always_ff @(posedge clk) begin
    if (take) begin
      iop <= op;
      ia  <= first_operand;
      ib  <= second_operand;
    end
    if (cmd.read) begin
      rd    <= rf[ra];
      rs    <= rf[rbi];
      mem_q <= dmem[ib[MB-1:0]];
      stk_q <= dstk[SB'(dsp - 1'b1)];
    end
    if (cmd.rest_rd) frm_q <= frames[base + FB'(cnt)];
  end

  logic [31:0] res, divb, mulv;
  logic        wr_reg;
  logic [31:0] pcx;
  assign divb = (iop == OP_DIV) ? rs : ib;
  assign mulv = rd * ((iop == OP_MUL) ? rs : ib);

  always_comb begin
    res = rd;
    wr_reg = 1'b0;
    case (iop)
      OP_POP:   begin res = stk_q; wr_reg = dsp != 0; end
      OP_ADD:   begin res = rd + rs; wr_reg = 1'b1; end
      OP_MUL, OP_MULI: begin res = mulv; wr_reg = 1'b1; end
      OP_SUB:   begin res = rd - rs; wr_reg = 1'b1; end
      OP_ADDI:  begin res = rd + ib; wr_reg = 1'b1; end
      OP_SUBI:  begin res = rd - ib; wr_reg = 1'b1; end
      OP_LOAD:  begin res = mem_q; wr_reg = ib < 32'(MEM_WORDS); end
      OP_LOADI: begin res = ib; wr_reg = 1'b1; end
      OP_MOV:   begin res = rs; wr_reg = 1'b1; end
      OP_COM:   begin res = ~rd; wr_reg = 1'b1; end
      OP_NEG:   begin res = 32'd0 - rd; wr_reg = 1'b1; end
      OP_CLR:   begin res = '0; wr_reg = 1'b1; end
      OP_SET:   begin res = '1; wr_reg = 1'b1; end
      OP_INC:   begin res = rd + 32'd1; wr_reg = 1'b1; end
      OP_DEC:   begin res = rd - 32'd1; wr_reg = 1'b1; end
      default:  ;
    endcase
    if (idx_bad) wr_reg = 1'b0;
  end

  always_comb begin
    fault_c = F_NONE;
    pcx = 32'(pc) + 32'd1;
    if (idx_bad) fault_c = F_INDEX;
    else begin
      case (iop)
        OP_POP:  if (dsp == 0) fault_c = F_UNDER;
        OP_PUSH: if (dsp >= (SB+1)'(STACK_DEPTH)) fault_c = F_OVER;
        OP_DIV:  if (rs == 0) fault_c = F_DIVZ;
        OP_DIVI: if (ib == 0) fault_c = F_DIVZ;
        OP_LOAD: if (ib >= 32'(MEM_WORDS)) fault_c = F_INDEX;
        OP_ST:   if (rd >= 32'(MEM_WORDS)) fault_c = F_INDEX;
        OP_CALL: if (depth >= CB'(CALL_LEVELS)) fault_c = F_OVER;
        OP_RET:  if (depth == 0) fault_c = F_UNDER;
        OP_JMP:  pcx = 32'(pc) + ia + 32'd1;
        OP_JMPC: if (cstat) pcx = 32'(pc) + ia + 32'd1;
        OP_JMPBC: if (cstat) pcx = 32'(pc) - ia;
        OP_SIS:  if (cstat) pcx = 32'(pc) + 32'd2;
        OP_HALT: pcx = 32'(pc);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dq   <= rd[31] ? 32'd0 - rd : rd;
      dd   <= divb[31] ? 32'd0 - divb : divb;
      dr   <= '0;
      dneg <= rd[31] ^ divb[31];
    end else if (cmd.div_step) begin
      if (!trial[32]) dr <= trial[31:0];
      else dr <= {dr[30:0], dq[31]};
      dq <= {dq[30:0], !trial[32]};
    end
    if (cmd.exec && fault_c == F_NONE && iop == OP_PUSH) dstk[dsp[SB-1:0]] <= rd;
    if (cmd.exec && fault_c == F_NONE && iop == OP_ST) dmem[rd[MB-1:0]] <= rs;
    if (cmd.save_step) frames[base + FB'(cnt)] <= save_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) rf[i] <= '0;
      cstat <= 1'b0;
      pc    <= '0;
      dsp   <= '0;
      depth <= '0;
      cnt   <= '0;
      dcnt  <= '0;
      print_valid <= 1'b0;
    end else begin
      if (cmd.read) begin
        cnt  <= '0;
        dcnt <= 5'd31;
      end
      if (cmd.div_step) dcnt <= dcnt - 1'b1;
      if (cmd.div_done) begin
        rf[ra] <= dneg ? 32'd0 - dq : dq;
        pc <= PC_BITS'(pcx);
        print_valid <= 1'b0; print_value <= '0; halted <= 1'b0;
        fault_q <= F_NONE;
      end
      if (cmd.exec) begin
        if (wr_reg) rf[ra] <= res;
        if (fault_c == F_NONE) begin
          if (iop == OP_EQ)  cstat <= rd == rs;
          if (iop == OP_NEQ) cstat <= rd != rs;
          if (iop == OP_POP)  dsp <= dsp - 1'b1;
          if (iop == OP_PUSH) dsp <= dsp + 1'b1;
        end
        pc <= PC_BITS'(pcx);
        print_valid <= fault_c == F_NONE && iop == OP_PRINT;
        print_value <= (fault_c == F_NONE && iop == OP_PRINT) ? rd : '0;
        halted  <= fault_c == F_NONE && iop == OP_HALT;
        fault_q <= fault_c;
      end
      if (cmd.save_step) cnt <= cnt + 1'b1;
      if (cmd.save_done) begin
        depth <= depth + 1'b1;
        pc <= PC_BITS'(ia);
        print_valid <= 1'b0; print_value <= '0; halted <= 1'b0;
        fault_q <= F_NONE;
      end
      if (cmd.rest_rd && !cmd.rest_step) cnt <= cnt + 1'b1;
      if (cmd.rest_step) begin
        if (cnt <= (RB+1)'(REG_COUNT)) rf[RB'(cnt - 1'b1)] <= frm_q;
        cnt <= cnt + 1'b1;
      end
      if (cmd.rest_done) begin
        // The last two frame words were read during the final restore cycles.
        cstat <= cst_q;
        pc    <= PC_BITS'(frm_q + 32'd1);
        depth <= depth - 1'b1;
        print_valid <= 1'b0; print_value <= '0; halted <= 1'b0;
        fault_q <= F_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rest_step && cnt == (RB+1)'(REG_COUNT + 1)) cst_q <= frm_q[0];
  end

  assign next_pc = 16'(pc);
  assign fault   = fault_q;

endmodule

// ===== sv/stack_register_vm_executor_unit.sv =====
// Top level of the register-machine instruction executor.
// One instruction enters per item and yields one result: next PC, PRINT value,
// halt flag and fault code. Simple instructions pass through a register/memory
// read, then execute and commit; DIV and DIVI with a nonzero divisor run a
// one-bit-per-cycle restoring divider over 32 quotient bits; CALL copies
// REG_COUNT registers, the status and the PC into a frame one word per cycle
// and RET walks the frame back one word per cycle.
// The next item is taken once the previous result has left the output register,
// or in the same cycle that it leaves.
module stack_register_vm_executor_unit
  import srvm_pkg::*;
#(
  parameter int REG_COUNT   = 32,
  parameter int MEM_WORDS   = 4096,
  parameter int STACK_DEPTH = 256,
  parameter int CALL_LEVELS = 16,
  parameter int PC_BITS     = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [4:0]         op,
  input  logic signed [31:0] first_operand,
  input  logic signed [31:0] second_operand,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        next_pc,
  output logic               print_valid,
  output logic signed [31:0] print_value,
  output logic               halted,
  output logic [2:0]         fault
);

  srvm_cmd_t  cmd;
  srvm_stat_t stat;

  srvm_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd
  );

  srvm_dp #(
    .REG_COUNT(REG_COUNT), .MEM_WORDS(MEM_WORDS), .STACK_DEPTH(STACK_DEPTH),
    .CALL_LEVELS(CALL_LEVELS), .PC_BITS(PC_BITS)
  ) u_dp (
    .clk, .rst, .take(in_valid && in_ready), .op, .first_operand, .second_operand,
    .cmd, .stat, .next_pc, .print_valid, .print_value, .halted, .fault
  );

endmodule

// ===== tb/tb.sv =====
// Testbench for the register-machine executor: random programs checked against a local model.
module tb
  import srvm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NREGS   = 32;
  localparam int NWORDS  = 4096;
  localparam int SDEPTH  = 256;
  localparam int NLEVELS = 16;

  typedef struct packed {
    logic [4:0]  op;
    logic [31:0] a;
    logic [31:0] b;
  } instr_t;

  typedef struct packed {
    logic [15:0] npc;
    logic        pv;
    logic [31:0] pval;
    logic        halt;
    logic [2:0]  flt;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [4:0] op = '0;
  logic signed [31:0] first_operand = '0;
  logic signed [31:0] second_operand = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] next_pc;
  logic print_valid;
  logic signed [31:0] print_value;
  logic halted;
  logic [2:0] fault;

  stack_register_vm_executor_unit dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .first_operand(first_operand), .second_operand(second_operand),
    .out_valid(out_valid), .out_ready(out_ready), .next_pc(next_pc),
    .print_valid(print_valid), .print_value(print_value), .halted(halted),
    .fault(fault)
  );

  always #4 clk = ~clk;

  // Model state of the machine.
  logic [31:0] regs [NREGS];
  logic        status;
  logic [15:0] pc;
  logic [31:0] mem [NWORDS];
  bit          mem_written [NWORDS];
  logic [31:0] dstack [SDEPTH];
  int          dsp;
  logic [31:0] frame_regs [NLEVELS][NREGS];
  logic        frame_status [NLEVELS];
  logic [15:0] frame_pc [NLEVELS];
  int          depth;

  instr_t   pending_instrs[$];
  outcome_t expected_outcomes[$];
  int  errors = 0;
  int  mismatches = 0;
  bit  quiet = 1'b0;
  int  send_gap = 0;
  int  recv_gap = 0;
  bit  hold_sender = 1'b0;
  bit  in_taken = 1'b0;

  function automatic logic [31:0] quotient(logic [31:0] x, logic [31:0] y);
    logic [31:0] ux, uy, q;
    ux = x[31] ? -x : x;
    uy = y[31] ? -y : y;
    q = ux / uy;
    return (x[31] != y[31]) ? -q : q;
  endfunction

  // Executes one instruction on the model and returns the expected result.
  function automatic outcome_t execute(instr_t ins);
    outcome_t r;
    logic [15:0] npc;
    logic [2:0] f;
    logic ua, ub, ra, rb;
    logic [31:0] d, s;
    int ia, ib;
    npc = pc + 16'd1;
    f = F_NONE;
    r = '0;
    ra = ins.a < NREGS;
    rb = ins.b < NREGS;
    ua = (ins.op <= OP_MOV) || ins.op == OP_COM || ins.op == OP_NEG ||
         ins.op == OP_PRINT || (ins.op >= OP_EQ && ins.op <= OP_DEC);
    ub = (ins.op >= OP_ADD && ins.op <= OP_DIV) || ins.op == OP_MOV ||
         ins.op == OP_EQ || ins.op == OP_NEQ || ins.op == OP_ST;
    if ((ua && !ra) || (ub && !rb)) begin
      f = F_INDEX;
    end else begin
      ia = ra ? int'(ins.a) : 0;
      ib = rb ? int'(ins.b) : 0;
      d = regs[ia];
      s = regs[ib];
      case (ins.op)
        OP_POP: begin
          if (dsp == 0) f = F_UNDER;
          else begin
            dsp--;
            regs[ia] = dstack[dsp];
          end
        end
        OP_PUSH: begin
          if (dsp >= SDEPTH) f = F_OVER;
          else begin
            dstack[dsp] = d;
            dsp++;
          end
        end
        OP_ADD:  regs[ia] = d + s;
        OP_MUL:  regs[ia] = d * s;
        OP_SUB:  regs[ia] = d - s;
        OP_DIV:  if (s == 0) f = F_DIVZ; else regs[ia] = quotient(d, s);
        OP_ADDI: regs[ia] = d + ins.b;
        OP_MULI: regs[ia] = d * ins.b;
        OP_SUBI: regs[ia] = d - ins.b;
        OP_DIVI: if (ins.b == 0) f = F_DIVZ; else regs[ia] = quotient(d, ins.b);
        OP_LOAD: if (ins.b >= NWORDS) f = F_INDEX; else regs[ia] = mem[ins.b];
        OP_LOADI: regs[ia] = ins.b;
        OP_MOV:  regs[ia] = s;
        OP_JMP:  npc = pc + ins.a[15:0] + 16'd1;
        OP_JMPC: if (status) npc = pc + ins.a[15:0] + 16'd1;
        OP_COM:  regs[ia] = ~d;
        OP_NEG:  regs[ia] = -d;
        OP_CALL: begin
          if (depth >= NLEVELS) f = F_OVER;
          else begin
            for (int i = 0; i < NREGS; i++) frame_regs[depth][i] = regs[i];
            frame_status[depth] = status;
            frame_pc[depth] = pc;
            depth++;
            npc = ins.a[15:0];
          end
        end
        OP_RET: begin
          if (depth == 0) f = F_UNDER;
          else begin
            depth--;
            for (int i = 0; i < NREGS; i++) regs[i] = frame_regs[depth][i];
            status = frame_status[depth];
            npc = frame_pc[depth] + 16'd1;
          end
        end
        OP_PRINT: begin
          r.pv = 1'b1;
          r.pval = d;
        end
        OP_EQ:  status = (d == s);
        OP_NEQ: status = (d != s);
        OP_CLR: regs[ia] = '0;
        OP_SET: regs[ia] = '1;
        OP_ST: begin
          if (d >= NWORDS) f = F_INDEX;
          else begin
            mem[d] = s;
            mem_written[d] = 1'b1;
          end
        end
        OP_INC: regs[ia] = d + 32'd1;
        OP_DEC: regs[ia] = d - 32'd1;
        OP_JMPBC: if (status) npc = pc - ins.a[15:0];
        OP_SIS:   if (status) npc = pc + 16'd2;
        OP_HALT: begin
          r.halt = 1'b1;
          npc = pc;
        end
        default: ;
      endcase
    end
    if (f != F_NONE) begin
      npc = pc + 16'd1;
      r.pv = 1'b0;
      r.pval = '0;
    end
    pc = npc;
    r.npc = npc;
    r.flt = f;
    return r;
  endfunction

  // Queues an instruction. A LOAD from a word never stored is not allowed, so
  // such an address is moved to word 7 if that was written, else out of range.
  task automatic enqueue(logic [4:0] o, logic [31:0] a, logic [31:0] b);
    instr_t ins;
    if (o == OP_LOAD && a < NREGS && b < NWORDS && !mem_written[b]) begin
      b = 32'd7;
      if (!mem_written[7]) b = 32'd5000;
    end
    ins = '{op: o, a: a, b: b};
    pending_instrs.push_back(ins);
    expected_outcomes.push_back(execute(ins));
  endtask

  function automatic logic [31:0] rand_reg();
    return $urandom_range(0, 99) < 95 ? 32'($urandom_range(0, NREGS - 1)) : $urandom;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'($urandom_range(0, 20)) - 32'd10;
      default: return $urandom;
    endcase
  endfunction

  // Acceptance is seen at the rising edge and acted on at the next falling edge.
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && in_ready;
  end

  // Driver: new items are presented at the falling edge, after the previous
  // one was accepted; valid stays up until acceptance.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        void'(pending_instrs.pop_front());
      end
      if (!in_valid || in_taken) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_instrs.size() > 0 && !hold_sender) begin
          op <= pending_instrs[0].op;
          first_operand <= pending_instrs[0].a;
          second_operand <= pending_instrs[0].b;
          in_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 12);
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) recv_gap <= $urandom_range(1, 12);
      end
    end
  end

  // The driver pops at the falling edge after acceptance, so the head of the
  // queue is the item on the pins.
  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_outcomes.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result next_pc=%0d", next_pc);
      end else begin
        want = expected_outcomes.pop_front();
        if (next_pc !== want.npc || print_valid !== want.pv ||
            print_value !== want.pval || halted !== want.halt || fault !== want.flt) begin
          errors++;
          if (mismatches++ < 10)
            $display({"mismatch: exp pc=%0d pv=%0b pval=%0d halt=%0b fault=%0d, ",
                      "got pc=%0d pv=%0b pval=%0d halt=%0b fault=%0d"},
                     want.npc, want.pv, $signed(want.pval), want.halt, want.flt,
                     next_pc, print_valid, print_value, halted, fault);
        end
      end
    end
  end

  initial begin
    logic [4:0] o;
    int n;
    for (int i = 0; i < NREGS; i++) regs[i] = '0;
    for (int i = 0; i < NWORDS; i++) mem_written[i] = 1'b0;
    status = 1'b0;
    pc = '0;
    dsp = 0;
    depth = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part: extremes, faults, and opcodes including the unused ones.
    enqueue(OP_POP, 0, 0);                 // empty data stack
    enqueue(OP_RET, 0, 0);                 // call depth zero
    enqueue(OP_LOADI, 1, 32'h8000_0000);
    enqueue(OP_SET, 2, 0);
    enqueue(OP_DIV, 1, 2);                 // most negative divided by minus one
    enqueue(OP_DIVI, 1, 0);                // divide by zero
    enqueue(OP_DIV, 3, 4);                 // divide by zero register
    enqueue(OP_ADD, 32, 0);                // bad register index
    enqueue(OP_MOV, 0, 32'hffff_ffff);
    enqueue(OP_ST, 2, 1);                  // address out of range
    enqueue(OP_LOADI, 5, 7);
    enqueue(OP_ST, 5, 1);
    enqueue(OP_LOAD, 6, 7);
    enqueue(OP_LOAD, 6, 4096);
    enqueue(OP_EQ, 6, 1);
    enqueue(OP_JMPC, 32'h7fff_ffff, 0);
    enqueue(OP_SIS, 0, 0);
    enqueue(OP_JMPBC, 32'h8000_0000, 0);
    enqueue(OP_CALL, 32'hffff_ffff, 0);
    enqueue(OP_PRINT, 1, 0);
    enqueue(OP_RET, 0, 0);
    enqueue(OP_HALT, 0, 0);
    enqueue(5'd30, 0, 0);
    enqueue(5'd31, 32'hffff_ffff, 32'hffff_ffff);
    for (int i = 0; i < NLEVELS + 1; i++) enqueue(OP_CALL, $urandom, 0); // overflow
    for (int i = 0; i < NLEVELS; i++) enqueue(OP_RET, 0, 0);
    for (int i = 0; i < SDEPTH + 1; i++) enqueue(OP_PUSH, rand_reg(), 0); // overflow

    // Once everything has drained, pause the sender, then release it.
    wait (pending_instrs.size() == 0 && expected_outcomes.size() == 0);
    hold_sender = 1'b1;
    repeat (50) @(posedge clk);
    hold_sender = 1'b0;

    // Random programs, mostly with valid register indexes.
    n = 0;
    while (n < 230) begin
      if (n == 180) begin
        wait (pending_instrs.size() == 0);
        quiet = 1'b1;
      end
      o = 5'($urandom_range(0, 31));
      if ((o == OP_CALL && depth >= NLEVELS - 1 && $urandom_range(0, 3) != 0) ||
          (o == OP_RET && depth == 0 && $urandom_range(0, 3) != 0))
        o = OP_ADD;
      if (o == OP_ST && $urandom_range(0, 1) == 1) begin
        // Aim stores at small addresses so later loads find data.
        enqueue(OP_LOADI, 9, 32'($urandom_range(0, 15)));
        n++;
        enqueue(OP_ST, 9, rand_reg());
      end else if (o == OP_LOAD) begin
        enqueue(o, rand_reg(),
                $urandom_range(0, 19) == 0 ? $urandom : 32'($urandom_range(0, 15)));
      end else if (o == OP_DIVI || o == OP_ADDI || o == OP_MULI || o == OP_SUBI ||
                   o == OP_LOADI) begin
        enqueue(o, rand_reg(), rand_word());
      end else if (o == OP_JMP || o == OP_JMPC || o == OP_JMPBC || o == OP_CALL) begin
        enqueue(o, rand_word(), $urandom);
      end else begin
        enqueue(o, rand_reg(), rand_reg());
      end
      n++;
      // Keep the driver queue short so the model and stimulus stay close.
      wait (pending_instrs.size() < 8);
    end
    wait (pending_instrs.size() == 0 && expected_outcomes.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/srvm_pkg.sv
sv/srvm_ctrl.sv
sv/srvm_dp.sv
sv/stack_register_vm_executor_unit.sv
tb/tb.sv
